// ===== rtl/core/bple_pkg.sv =====
package bple_pkg;

	localparam int VW = 17;
	localparam int NW = 43;
	localparam int MB = 32;
	localparam int DW = 25;
	localparam int PW = NW + MB;
	localparam int CNT_W = 7;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_LFO_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_DIV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_RATE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd7;

	localparam logic [2:0] KIND_GATE_ON = 3'd0;
	localparam logic [2:0] KIND_GATE_OFF = 3'd1;
	localparam logic [2:0] KIND_EVAL = 3'd2;
	localparam logic [2:0] KIND_APPEND = 3'd3;
	localparam logic [2:0] KIND_UPDATE = 3'd4;
	localparam logic [2:0] KIND_DELETE = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] TRIG_WRAP = 2'd0;
	localparam logic [1:0] TRIG_ENV = 2'd1;
	localparam logic [1:0] TRIG_OFF = 2'd2;

	localparam logic [3:0] BEAT_DIV_MAX = 4'd12;
	localparam logic [VW-1:0] Q_ONE = 17'h10000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] left_key;
		logic [7:0] right_key;
		logic [VW-1:0] seg_x_start;
		logic [VW-1:0] seg_x_end;
		logic [VW-1:0] seg_y_start;
		logic [VW-1:0] seg_y_end;
	} in_item_t;

	typedef struct packed {
		logic [VW-1:0] envelope_value;
		logic [VW-1:0] phase_out;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic go;
		logic [NW-1:0] a;
		logic [MB-1:0] b;
		logic [DW-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic [VW-1:0] q;
		logic q_hi;
	} md_rsp_t;

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE, SQ_NUM, SQ_DEN, SQ_GO, SQ_WAIT, SQ_PHASE, SQ_SRCH_RD,
		SQ_SRCH_CHK, SQ_INTERP, SQ_SHIFT_RD, SQ_SHIFT_WR, SQ_DONE
	} seq_state_t;

	// log2 of the beat division denominator
	function automatic logic [3:0] div_shift(input logic [3:0] idx);
		logic [3:0] r;
		case (idx)
			4'd0: r = 4'd6;
			4'd1: r = 4'd5;
			4'd2: r = 4'd4;
			4'd3: r = 4'd3;
			4'd4: r = 4'd2;
			4'd5: r = 4'd1;
			4'd7: r = 4'd1;
			4'd9: r = 4'd1;
			4'd11: r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// 15 times the beat division numerator
	function automatic logic [6:0] div_k(input logic [3:0] idx);
		logic [6:0] r;
		case (idx)
			4'd7: r = 7'd45;
			4'd8: r = 7'd30;
			4'd9: r = 7'd75;
			4'd10: r = 7'd45;
			4'd11: r = 7'd105;
			4'd12: r = 7'd60;
			default: r = 7'd15;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/breakpoint_lfo_envelope.sv =====
// Gate on/off, append and unused kinds need no table search; update and delete search
// the table; an enabled evaluate with a nonzero gate count searches it too and uses the
// shared multiply/divide unit twice (32 multiply and 75 divide steps per use).
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset clears control state, count and flags; payload and table contents stay undefined.
module breakpoint_lfo_envelope import bple_pkg::*; #(
	parameter int MAX_SEGMENTS = 16,
	parameter int KEY_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int KW = 2 * KEY_BITS;
	localparam int EW = KW + 4 * VW;
	localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);

	seq_state_t state_q, state_d;

	logic enable_q, rate_mode_q;
	logic [1:0] trig_q;
	logic [3:0] beat_q;
	logic [22:0] free_q;
	logic [17:0] tempo_q;
	logic [12:0] blen_q;
	logic [17:0] srate_q;

	logic running_q;
	logic [31:0] bcount_q;
	logic [VW-1:0] phase_q, saved_q, held_q;
	logic [CW-1:0] seg_count_q, idx_q;
	logic interp_q;
	logic out_valid_q;

	logic [2:0] kind_q;
	logic [KW-1:0] key_q;
	logic [4*VW-1:0] entry_q;
	logic [1:0] status_q;
	logic [VW-1:0] ys_q;
	logic neg_q;
	logic [NW-1:0] opa_q;
	logic [MB-1:0] opb_q;
	logic [DW-1:0] opd_q;
	out_item_t out_q;

	logic accept, out_free;
	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [KW-1:0] key_in, r_key;
	logic [VW-1:0] r_xs, r_xe, r_ys, r_ye;
	logic in_range, seg_hit, more, shift_more;
	logic [CW-1:0] idx_nxt;
	logic [22:0] mul_a;
	logic [12:0] mul_b;
	logic [35:0] prod;
	logic [17:0] sr1;
	logic [6:0] k;
	logic [VW-1:0] new_phase;
	logic [VW:0] interp_sum;
	md_req_t md_req;
	md_rsp_t md_rsp;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != SQ_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign key_in = {KEY_BITS'(in_data.left_key), KEY_BITS'(in_data.right_key)};
	assign r_key = ram_rdata[EW-1:4*VW];
	assign r_xs = ram_rdata[4*VW-1:3*VW];
	assign r_xe = ram_rdata[3*VW-1:2*VW];
	assign r_ys = ram_rdata[2*VW-1:VW];
	assign r_ye = ram_rdata[VW-1:0];

	assign in_range = phase_q >= r_xs && phase_q < r_xe;
	assign seg_hit = (kind_q == KIND_EVAL) ? in_range : (r_key == key_q);
	assign idx_nxt = idx_q + 1'b1;
	assign more = idx_q < seg_count_q;
	assign shift_more = idx_nxt < seg_count_q;

	// shared small multiplier: numerator base in SQ_NUM, denominator in SQ_DEN
	assign sr1 = (srate_q == '0) ? 18'd1 : srate_q;
	assign k = rate_mode_q ? 7'd1 : div_k(beat_q);
	assign mul_a = (state_q == SQ_DEN) ? 23'(sr1) : (rate_mode_q ? free_q : 23'(tempo_q));
	assign mul_b = (state_q == SQ_DEN) ? 13'(k) : blen_q;
	assign prod = mul_a * mul_b;

	always_comb begin
		case (trig_q)
			TRIG_ENV: new_phase = (md_rsp.q_hi || md_rsp.q[VW-1]) ? Q_ONE :
				{1'b0, md_rsp.q[VW-2:0]};
			TRIG_OFF: new_phase = {1'b0, md_rsp.q[VW-2:0] + saved_q[VW-2:0]};
			default: new_phase = {1'b0, md_rsp.q[VW-2:0]};
		endcase
	end

	assign interp_sum = neg_q ? ({1'b0, ys_q} - {1'b0, md_rsp.q}) :
		({1'b0, ys_q} + {1'b0, md_rsp.q});

	assign md_req.go = state_q == SQ_GO;
	assign md_req.a = opa_q;
	assign md_req.b = opb_q;
	assign md_req.d = opd_q;

	assign ram_raddr = (state_q == SQ_SHIFT_RD) ? idx_nxt[IW-1:0] : idx_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			SQ_IDLE: begin
				ram_waddr = seg_count_q[IW-1:0];
				ram_wdata = {key_in, in_data.seg_x_start, in_data.seg_x_end,
					in_data.seg_y_start, in_data.seg_y_end};
				if (accept) begin
					state_d = SQ_DONE;
					case (in_data.kind)
						KIND_EVAL: begin
							if (enable_q && bcount_q != '0) begin
								state_d = SQ_NUM;
							end
						end
						KIND_APPEND: ram_we = seg_count_q < SEG_MAX;
						KIND_UPDATE: state_d = SQ_SRCH_RD;
						KIND_DELETE: state_d = SQ_SRCH_RD;
						default: ;
					endcase
				end
			end
			SQ_NUM: state_d = SQ_DEN;
			SQ_DEN: state_d = SQ_GO;
			SQ_GO: state_d = SQ_WAIT;
			SQ_WAIT: begin
				if (!md_rsp.busy) begin
					state_d = interp_q ? SQ_INTERP : SQ_PHASE;
				end
			end
			SQ_PHASE: state_d = SQ_SRCH_RD;
			SQ_SRCH_RD: state_d = more ? SQ_SRCH_CHK : SQ_DONE;
			SQ_SRCH_CHK: begin
				ram_wdata = {key_q, entry_q};
				if (!seg_hit) begin
					state_d = SQ_SRCH_RD;
				end else begin
					case (kind_q)
						KIND_EVAL: state_d = SQ_GO;
						KIND_UPDATE: begin
							ram_we = 1'b1;
							state_d = SQ_DONE;
						end
						default: state_d = SQ_SHIFT_RD;
					endcase
				end
			end
			SQ_SHIFT_RD: state_d = shift_more ? SQ_SHIFT_WR : SQ_DONE;
			SQ_SHIFT_WR: begin
				ram_we = 1'b1;
				state_d = SQ_SHIFT_RD;
			end
			SQ_INTERP: state_d = SQ_DONE;
			SQ_DONE: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_mode_q <= 1'b0;
			trig_q <= TRIG_WRAP;
			beat_q <= 4'd6;
			free_q <= 23'd65536;
			tempo_q <= 18'd30720;
			blen_q <= 13'd512;
			srate_q <= 18'd48000;
			running_q <= 1'b0;
			bcount_q <= '0;
			phase_q <= '0;
			saved_q <= '0;
			held_q <= '0;
			seg_count_q <= '0;
			idx_q <= '0;
			interp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						interp_q <= 1'b0;
						case (in_data.kind)
							KIND_GATE_ON: begin
								if (enable_q) begin
									running_q <= 1'b1;
								end
								if ((enable_q || running_q) && bcount_q != '1) begin
									bcount_q <= bcount_q + 1'b1;
								end
							end
							KIND_GATE_OFF: begin
								saved_q <= phase_q;
								bcount_q <= '0;
								running_q <= 1'b0;
							end
							KIND_EVAL: begin
								if (enable_q && bcount_q == '0) begin
									held_q <= '0;
								end
							end
							KIND_APPEND: begin
								if (seg_count_q < SEG_MAX) begin
									seg_count_q <= seg_count_q + 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				SQ_PHASE: begin
					phase_q <= new_phase;
					idx_q <= '0;
				end
				SQ_SRCH_CHK: begin
					if (!seg_hit) begin
						idx_q <= idx_nxt;
					end else if (kind_q == KIND_EVAL) begin
						interp_q <= 1'b1;
					end
				end
				SQ_SHIFT_RD: begin
					if (!shift_more) begin
						seg_count_q <= seg_count_q - 1'b1;
					end
				end
				SQ_SHIFT_WR: idx_q <= idx_nxt;
				SQ_INTERP: held_q <= interp_sum[VW-1:0];
				default: ;
			endcase

			if (state_q == SQ_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_LFO_ENABLE: enable_q <= cfg_data[0];
					CFG_RATE_MODE: rate_mode_q <= cfg_data[0];
					CFG_TRIGGER_MODE: begin
						if (cfg_data[1:0] == TRIG_WRAP || cfg_data[1:0] == TRIG_ENV) begin
							trig_q <= cfg_data[1:0];
						end else if (cfg_data[1:0] == TRIG_OFF) begin
							trig_q <= TRIG_OFF;
							saved_q <= '0;
						end
					end
					CFG_BEAT_DIV: begin
						if (cfg_data[3:0] <= BEAT_DIV_MAX) begin
							beat_q <= cfg_data[3:0];
						end
					end
					CFG_FREE_RATE: free_q <= cfg_data[22:0];
					CFG_TEMPO: tempo_q <= cfg_data[17:0];
					CFG_BLOCK_LEN: blen_q <= cfg_data[12:0];
					CFG_SAMPLE_RATE: srate_q <= cfg_data[17:0];
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					kind_q <= in_data.kind;
					key_q <= key_in;
					entry_q <= {in_data.seg_x_start, in_data.seg_x_end,
						in_data.seg_y_start, in_data.seg_y_end};
					status_q <= (in_data.kind == KIND_APPEND && seg_count_q >= SEG_MAX) ?
						ST_FULL : ST_OK;
				end
			end
			SQ_NUM: begin
				if (rate_mode_q) begin
					opa_q <= NW'(prod);
				end else begin
					opa_q <= NW'(prod) << (div_shift(beat_q) + 4'd6);
				end
			end
			SQ_DEN: begin
				opd_q <= DW'(prod);
				opb_q <= bcount_q;
			end
			SQ_SRCH_RD: begin
				if (!more && kind_q != KIND_EVAL) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			SQ_SRCH_CHK: begin
				if (seg_hit && kind_q == KIND_EVAL) begin
					ys_q <= r_ys;
					neg_q <= r_ye < r_ys;
					opa_q <= NW'((r_ye < r_ys) ? (r_ys - r_ye) : (r_ye - r_ys));
					opb_q <= MB'(phase_q - r_xs);
					opd_q <= DW'(r_xe - r_xs);
				end
			end
			SQ_DONE: begin
				if (out_free) begin
					out_q.envelope_value <= held_q;
					out_q.phase_out <= phase_q;
					out_q.status <= status_q;
				end
			end
			default: ;
		endcase
	end

	bple_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bple_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

endmodule

// ===== rtl/core/bple_ram.sv =====
module bple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bple_muldiv.sv =====
// a * b, then / d: shift-add multiply, then restoring divide, one bit a cycle
module bple_muldiv import bple_pkg::*; (
	input logic clk,
	input logic arst_n,
	input md_req_t req,
	output md_rsp_t rsp
);

	md_state_t st_q, st_d;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0] acc_q;
	logic [NW-1:0] a_q;
	logic [MB-1:0] b_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;
	logic [VW-1:0] q_q;
	logic hi_q;

	logic [DW:0] trial;
	logic ge;

	assign trial = {rem_q, acc_q[PW-1]};
	assign ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == MD_IDLE || st_d != st_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			MD_IDLE: begin
				if (req.go) begin
					st_d = MD_MUL;
				end
			end
			MD_MUL: begin
				if (cnt_q == CNT_W'(MB - 1)) begin
					st_d = MD_DIV;
				end
			end
			MD_DIV: begin
				if (cnt_q == CNT_W'(PW - 1)) begin
					st_d = MD_IDLE;
				end
			end
			default: st_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			MD_IDLE: begin
				if (req.go) begin
					a_q <= req.a;
					b_q <= req.b;
					d_q <= req.d;
					acc_q <= '0;
					rem_q <= '0;
					q_q <= '0;
					hi_q <= 1'b0;
				end
			end
			MD_MUL: begin
				acc_q <= {acc_q[PW-2:0], 1'b0} + (b_q[MB-1] ? PW'(a_q) : '0);
				b_q <= {b_q[MB-2:0], 1'b0};
			end
			MD_DIV: begin
				rem_q <= ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
				acc_q <= {acc_q[PW-2:0], 1'b0};
				q_q <= {q_q[VW-2:0], ge};
				hi_q <= hi_q | q_q[VW-1];
			end
			default: ;
		endcase
	end

	assign rsp.busy = st_q != MD_IDLE;
	assign rsp.q = q_q;
	assign rsp.q_hi = hi_q;

endmodule
